@@ src/gkag_pkg.sv @@
`default_nettype none
package gkag_pkg;

  localparam int PHASE_BITS       = 16;
  localparam int EASE_TABLE_DEPTH = 256;

  localparam int NUM_JOINTS  = 8;
  localparam int JOINT_W     = $clog2(NUM_JOINTS);
  localparam int ANGLE_W     = 16;
  localparam int PIPE_DRAIN  = 3;

  // Easing index runs 0..EASE_TABLE_DEPTH inclusive; the last entry is always 1.0.
  localparam int IDX_W  = $clog2(EASE_TABLE_DEPTH + 1);
  localparam int ADDR_W = $clog2(EASE_TABLE_DEPTH);
  localparam int WT_W   = 17;
  localparam logic [WT_W-1:0] WT_ONE = WT_W'(65536);

  localparam logic [1:0] KIND_FORWARD  = 2'd0;
  localparam logic [1:0] KIND_BACKWARD = 2'd1;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;

  typedef logic signed [8:0] key_row_t [0:3];
  typedef key_row_t key_tab_t [0:NUM_JOINTS-1];

  // Keyframe angles in degrees; columns are keyframe times 0, 1/4, 1/2 and 1.
  localparam key_tab_t KEY_ANGLES = '{
    '{ 9'sd57,   9'sd52,   -9'sd24,  9'sd38  },
    '{ -9'sd49,  -9'sd120, -9'sd28,  -9'sd77 },
    '{ -9'sd6,   9'sd42,   9'sd54,   9'sd55  },
    '{ -9'sd51,  -9'sd77,  -9'sd35,  -9'sd112},
    '{ -9'sd24,  9'sd38,   9'sd57,   9'sd52  },
    '{ -9'sd28,  -9'sd77,  -9'sd49,  -9'sd120},
    '{ 9'sd54,   9'sd55,   -9'sd6,   9'sd42  },
    '{ -9'sd35,  -9'sd112, -9'sd51,  -9'sd77 }
  };

  typedef logic [15:0] ease_tab_t [0:EASE_TABLE_DEPTH-1];

  // Shift and subtract quotient; only evaluated while the easing table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Cosine easing weight 0.5 - cos(x)/2 in Q1.16, from a Taylor series in Q2.30.
  function automatic logic [16:0] half_ease(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        den;
    logic signed [63:0] sum;
    logic [63:0]        w30;
    int                 n;
    x    = (PI_Q30 * 64'(k)) / EASE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    sum  = $signed(ONE_Q30);
    term = ONE_Q30;
    for (n = 1; n <= 20; n++) begin
      den  = 64'((2 * n - 1) * (2 * n));
      term = div_u64((term * x2) >> 30, den);
      if ((n & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    w30 = (ONE_Q30 - 64'(sum)) >> 1;
    return 17'((w30 + 64'd8192) >> 14);
  endfunction

  // The upper half of the table mirrors the lower half around 0.5.
  function automatic ease_tab_t build_ease_tab();
    ease_tab_t   tab;
    int unsigned k;
    for (k = 0; k < EASE_TABLE_DEPTH; k++) begin
      if (2 * k <= EASE_TABLE_DEPTH) begin
        tab[k] = 16'(half_ease(k));
      end else begin
        tab[k] = 16'(17'd65536 - half_ease(EASE_TABLE_DEPTH - k));
      end
    end
    return tab;
  endfunction

  localparam ease_tab_t EASE_TAB = build_ease_tab();

  typedef struct packed {
    logic               load_in;
    logic               upd_phase;
    logic               calc_idx;
    logic               load_wt;
    logic               issue;
    logic [JOINT_W-1:0] joint;
    logic               publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_key;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/gkag_ctrl.sv @@
`default_nettype none
module gkag_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  gkag_pkg::dp_status_t   status,
  output gkag_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PHASE   = 3'd1;
  localparam logic [2:0] S_INDEX   = 3'd2;
  localparam logic [2:0] S_WEIGHT  = 3'd3;
  localparam logic [2:0] S_JOINT   = 3'd4;
  localparam logic [2:0] S_DRAIN   = 3'd5;
  localparam logic [2:0] S_PUBLISH = 3'd6;

  localparam int CNT_W = gkag_pkg::JOINT_W;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.upd_phase = 1'b1;
        state_next    = status.is_key ? S_INDEX : S_IDLE;
      end
      S_INDEX: begin
        cmd.calc_idx = 1'b1;
        state_next   = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd.load_wt = 1'b1;
        cnt_next    = '0;
        state_next  = S_JOINT;
      end
      S_JOINT: begin
        cmd.issue = 1'b1;
        cmd.joint = cnt;
        if (cnt == CNT_W'(gkag_pkg::NUM_JOINTS - 1)) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        // Wait for the last joint to leave the four-stage angle pipeline.
        if (cnt == CNT_W'(gkag_pkg::PIPE_DRAIN - 1)) begin
          cnt_next   = '0;
          state_next = S_PUBLISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/gkag_datapath.sv @@
`default_nettype none
module gkag_datapath (
  input  wire                                        clk,
  input  wire                                        rst,
  input  gkag_pkg::ctrl_cmd_t                        cmd,
  output gkag_pkg::dp_status_t                       status,
  input  wire  [1:0]                                 in_kind,
  input  wire  [15:0]                                in_delta_time,
  input  wire                                        cfg_we,
  input  wire  [15:0]                                cfg_speed,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic [gkag_pkg::NUM_JOINTS*gkag_pkg::ANGLE_W-1:0] out_data
);

  localparam int PB     = gkag_pkg::PHASE_BITS;
  localparam int IDX_W  = gkag_pkg::IDX_W;
  localparam int ADDR_W = gkag_pkg::ADDR_W;
  localparam int WT_W   = gkag_pkg::WT_W;
  localparam int AW     = gkag_pkg::ANGLE_W;
  localparam int NJ     = gkag_pkg::NUM_JOINTS;
  localparam int JW     = gkag_pkg::JOINT_W;
  localparam int IP_W   = PB + IDX_W + 1;
  localparam int PA_W   = WT_W + 1 + 10;
  localparam int DEG_W  = 26;
  localparam int MAG_W  = 25;
  localparam int RP_W   = MAG_W + 25;

  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);
  localparam logic [PB-1:0] HALF    = PB'(1) << (PB - 1);

  logic [15:0]   speed;
  logic [PB-1:0] phase;
  logic [23:0]   prod;
  logic [1:0]    kind;
  logic [PB-1:0] inc;

  logic [1:0]      seg_c;
  logic [PB:0]     v_c;
  logic [IP_W-1:0] idx_sum;
  logic [IDX_W:0]  idx_raw;
  logic [1:0]      seg;
  logic [IDX_W-1:0] idx;
  logic [WT_W-1:0] wt;

  // Angle pipeline: A multiplies weight by the keyframe step, B forms the
  // signed degree value, C scales to radians, D rounds and applies direction.
  logic signed [8:0]      ang_a;
  logic signed [8:0]      ang_b;
  logic signed [9:0]      diff;
  logic signed [8:0]      a_sa;
  logic signed [PA_W-1:0] pa_sa;
  logic [JW-1:0]          j_sa;
  logic                   v_sa;

  logic signed [DEG_W-1:0] deg;
  logic [MAG_W-1:0]        mag_sb;
  logic                    neg_sb;
  logic [JW-1:0]           j_sb;
  logic                    v_sb;

  logic [RP_W-1:0] rp_sc;
  logic            neg_sc;
  logic [JW-1:0]   j_sc;
  logic            v_sc;

  logic [RP_W:0]   rsum;
  logic [AW-1:0]   rad;
  logic            neg_f;
  logic [AW-1:0]   result [0:NJ-1];
  logic [NJ*AW-1:0] packed_res;

  assign status.is_key   = (kind == gkag_pkg::KIND_FORWARD) ||
                           (kind == gkag_pkg::KIND_BACKWARD);
  assign status.out_free = !out_valid || out_ready;

  // Only the fraction of the Q8.24 product advances the phase.
  if (PB >= 24) begin : g_inc_wide
    assign inc = {prod, {(PB - 24){1'b0}}};
  end else begin : g_inc_narrow
    assign inc = prod[23 -: PB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= 16'd256;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        speed <= cfg_speed;
      end
      if (cmd.upd_phase) begin
        phase <= phase + inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      prod <= 24'(in_delta_time * speed);
      kind <= in_kind;
    end
  end

  // Segment and position within it; phase zero falls into segment 0 at weight 0.
  always_comb begin
    if (phase <= QUARTER) begin
      seg_c = 2'd0;
      v_c   = {phase[PB-2:0], 2'b00};
    end else if (phase <= HALF) begin
      seg_c = 2'd1;
      v_c   = {(phase[PB-2:0] - QUARTER[PB-2:0]), 2'b00};
    end else begin
      seg_c = 2'd2;
      v_c   = {1'b0, (phase[PB-2:0] - HALF[PB-2:0]), 1'b0};
    end
    idx_sum = IP_W'(v_c) * IP_W'(gkag_pkg::EASE_TABLE_DEPTH) + IP_W'(HALF);
    idx_raw = idx_sum[IP_W-1:PB];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_idx) begin
      seg <= seg_c;
      if (idx_raw > (IDX_W + 1)'(gkag_pkg::EASE_TABLE_DEPTH)) begin
        idx <= IDX_W'(gkag_pkg::EASE_TABLE_DEPTH);
      end else begin
        idx <= idx_raw[IDX_W-1:0];
      end
    end
    if (cmd.load_wt) begin
      if (idx == IDX_W'(gkag_pkg::EASE_TABLE_DEPTH)) begin
        wt <= gkag_pkg::WT_ONE;
      end else begin
        wt <= {1'b0, gkag_pkg::EASE_TAB[idx[ADDR_W-1:0]]};
      end
    end
  end

  always_comb begin
    ang_a = gkag_pkg::KEY_ANGLES[cmd.joint][seg];
    ang_b = gkag_pkg::KEY_ANGLES[cmd.joint][2'(seg + 2'd1)];
    diff  = 10'(ang_b) - 10'(ang_a);
    deg   = $signed({{(DEG_W - 25){a_sa[8]}}, a_sa, 16'h0000}) + DEG_W'(pa_sa);
    rsum  = (RP_W + 1)'(rp_sc) + ((RP_W + 1)'(1) << 33);
    rad   = rsum[34 +: AW];
    neg_f = neg_sc ^ (kind == gkag_pkg::KIND_FORWARD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sa <= 1'b0;
      v_sb <= 1'b0;
      v_sc <= 1'b0;
    end else begin
      v_sa <= cmd.issue;
      v_sb <= v_sa;
      v_sc <= v_sb;
    end
  end

  always_ff @(posedge clk) begin
    a_sa   <= ang_a;
    pa_sa  <= PA_W'($signed({1'b0, wt}) * diff);
    j_sa   <= cmd.joint;
    neg_sb <= deg[DEG_W-1];
    mag_sb <= MAG_W'(deg[DEG_W-1] ? -deg : deg);
    j_sb   <= j_sa;
    rp_sc  <= RP_W'(mag_sb * gkag_pkg::DEG2RAD_Q30);
    neg_sc <= neg_sb;
    j_sc   <= j_sb;
    if (v_sc) begin
      result[j_sc] <= neg_f ? AW'(-rad) : rad;
    end
  end

  always_comb begin
    for (int j = 0; j < NJ; j++) begin
      packed_res[j*AW +: AW] = result[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= packed_res;
    end
  end

endmodule
`default_nettype wire

@@ src/gait_keyframe_angle_generator_core.sv @@
// Channel  | Signals                                | Contents
// s_axis   | s_axis_tvalid/tready/tdata/tuser       | key event: kind, delta_time
// m_axis   | m_axis_tvalid/tready/tdata             | eight joint angles, Q4.12 radians
// cfg      | cfg_valid/cfg_ready/cfg_data           | speed, Q8.8 cycles per second
//
// A forward or backward event goes from acceptance to its result being loaded through
// phase update, easing index, table read, then one joint per cycle through a shared
// four-stage multiply pipeline. The next request is taken once the result is loaded;
// other kinds only advance the phase and give no result.
// Reset clears the phase to zero and sets speed to one cycle per second.
// A finished result waits in the output register while the next event is worked on;
// the next result is held back until that register is free.
`default_nettype none
module gait_keyframe_angle_generator_core (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [15:0]  s_axis_tdata,   // [15:0] delta_time
  input  wire  [1:0]   s_axis_tuser,   // [1:0] kind
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [15:0] front_upper_left, [31:16] front_lower_left, [47:32] back_upper_left,
  // [63:48] back_lower_left, [79:64] front_upper_right, [95:80] front_lower_right,
  // [111:96] back_upper_right, [127:112] back_lower_right
  output logic [127:0] m_axis_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [15:0]  cfg_data
);

  gkag_pkg::ctrl_cmd_t  cmd;
  gkag_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  gkag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gkag_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_kind       (s_axis_tuser),
    .in_delta_time (s_axis_tdata),
    .cfg_we        (cfg_valid),
    .cfg_speed     (cfg_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_data      (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ src/gkag_checker.sv @@
`default_nettype none
module gkag_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [127:0] m_axis_tdata
);

  // The block works on one event at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still in progress");

  // A result is only loaded while no request is being taken.
  a_publish_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input was open");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind gait_keyframe_angle_generator_core gkag_checker u_gkag_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ dv/tb_gait_keyframe_angle_generator_core.sv @@
`timescale 1ns / 1ps
module tb_gait_keyframe_angle_generator_core;

  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int NJ             = 8;
  localparam int EASE_DEPTH     = 256;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_EVENTS  = 1800;

  localparam longint unsigned PI_Q30_C       = 64'd3373259426;
  localparam longint unsigned ONE_Q30_C      = 64'd1073741824;
  localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

  typedef logic [NJ-1:0][15:0] joint_set_t;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid     = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data      = '0;

  gait_keyframe_angle_generator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keyframe angles in degrees at phase 0, 1/4, 1/2 and 1.
  int key_deg [0:NJ-1][0:3] = '{
    '{ 57,   52, -24,   38},
    '{-49, -120, -28,  -77},
    '{ -6,   42,  54,   55},
    '{-51,  -77, -35, -112},
    '{-24,   38,  57,   52},
    '{-28,  -77, -49, -120},
    '{ 54,   55,  -6,   42},
    '{-35, -112, -51,  -77}
  };

  string joint_names [0:NJ-1] = '{
    "front_upper_left", "front_lower_left", "back_upper_left", "back_lower_left",
    "front_upper_right", "front_lower_right", "back_upper_right", "back_lower_right"
  };

  int unsigned ease_q16 [0:EASE_DEPTH];
  logic [15:0] speed_model = 16'd256;
  logic [15:0] gait_phase_model = '0;
  joint_set_t  expected_angles_q [$];
  joint_set_t  want_angles;
  int          err_count = 0;
  int          src_idle_pct = 20;
  int          sink_stall_pct = 20;
  int          quiet_cycles = 0;

  // Lower half of the cosine easing curve, Taylor series in Q2.30, rounded to Q1.16.
  function automatic int unsigned cos_ease_q16(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned w30;
    longint          sum;
    x    = (PI_Q30_C * k) / EASE_DEPTH;
    x2   = (x * x) >> 30;
    sum  = longint'(ONE_Q30_C);
    term = ONE_Q30_C;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30_C)) begin
      sum = longint'(ONE_Q30_C);
    end
    w30 = (ONE_Q30_C - longint'(sum)) >> 1;
    return int'((w30 + 64'd8192) >> 14);
  endfunction

  task automatic build_ease_weights();
    for (int k = 0; k <= EASE_DEPTH; k++) begin
      if (2 * k <= EASE_DEPTH) begin
        ease_q16[k] = cos_ease_q16(k);
      end else begin
        ease_q16[k] = 65536 - cos_ease_q16(EASE_DEPTH - k);
      end
    end
  endtask

  // Advances the phase for every event; returns 1 when the event yields joint angles.
  function automatic bit predict_joint_angles(input logic [1:0] kind, input logic [15:0] dt,
                                              output joint_set_t angles);
    logic [31:0]     prod;
    int              p;
    int              v;
    int              idx;
    int              seg;
    longint          w;
    longint          a;
    longint          b;
    longint          deg;
    longint unsigned mag;
    longint unsigned rad;
    bit              neg;
    angles = '0;
    prod = 32'(dt) * 32'(speed_model);
    gait_phase_model = gait_phase_model + prod[23:8];
    if (kind != gkag_pkg::KIND_FORWARD && kind != gkag_pkg::KIND_BACKWARD) begin
      return 1'b0;
    end
    // Phase zero falls into the first segment with zero weight.
    p = int'(gait_phase_model);
    if (p <= 16384) begin
      seg = 0;
      v   = p * 4;
    end else if (p <= 32768) begin
      seg = 1;
      v   = (p - 16384) * 4;
    end else begin
      seg = 2;
      v   = (p - 32768) * 2;
    end
    idx = (v * EASE_DEPTH + 32768) >> 16;
    if (idx > EASE_DEPTH) begin
      idx = EASE_DEPTH;
    end
    w = longint'(ease_q16[idx]);
    for (int j = 0; j < NJ; j++) begin
      a   = key_deg[j][seg];
      b   = key_deg[j][seg + 1];
      deg = a * 65536 + w * (b - a);
      neg = deg < 0;
      mag = neg ? longint'(-deg) : longint'(deg);
      rad = (mag * RAD_PER_DEG_Q30 + (64'd1 << 33)) >> 34;
      if (kind == gkag_pkg::KIND_FORWARD) begin
        neg = !neg;
      end
      angles[j] = neg ? 16'(-rad) : 16'(rad);
    end
    return 1'b1;
  endfunction

  task automatic send_key_event(input logic [1:0] kind, input logic [15:0] dt);
    joint_set_t angles;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= dt;
    do @(posedge clk); while (!s_axis_tready);
    if (predict_joint_angles(kind, dt, angles)) begin
      expected_angles_q.push_back(angles);
    end
    @(negedge clk);
  endtask

  // Stops requests and waits for every pending result; optionally lets
  // trailing no-result events finish as well.
  task automatic wait_results_drained(input bit settle);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_angles_q.size() != 0);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(negedge clk);
    end
  endtask

  task automatic write_speed(input logic [15:0] value);
    wait_results_drained(1'b1);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    speed_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset speed is one cycle per second, so a delta of 0x4000 is a quarter cycle.
  task automatic test_phase_landmarks();
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h0000);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'h0000);
    send_key_event(KIND_OTHER, 16'h0000);
    send_key_event(KIND_UNUSED, 16'h0000);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h4000);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'h4000);
    send_key_event(KIND_OTHER, 16'h2000);
    send_key_event(KIND_UNUSED, 16'h2000);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'h0000);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h4000);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'h0001);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'hFFFF);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'hFFFF);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h8000);
  endtask

  task automatic test_speed_extremes();
    write_speed(16'h0000);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'hFFFF);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'h1234);
    write_speed(16'hFFFF);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'hFFFF);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'hFFFF);
    send_key_event(KIND_OTHER, 16'h8000);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h0001);
    write_speed(16'h0001);
    send_key_event(gkag_pkg::KIND_BACKWARD, 16'hFFFF);
    send_key_event(gkag_pkg::KIND_FORWARD, 16'h0100);
  endtask

  task automatic test_random_events();
    int unsigned r;
    logic [1:0]  kind;
    logic [15:0] dt;
    logic [15:0] speed_plan [0:5];
    speed_plan = '{16'd256, 16'($urandom), 16'hFFFF, 16'($urandom), 16'd1,
                   16'($urandom_range(64, 1024))};
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % 300 == 0) begin
        write_speed(speed_plan[i / 300]);
      end
      if (i == 600) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      if (i == 900) begin
        src_idle_pct   = 20;
        sink_stall_pct = 20;
      end
      if (i % 450 == 449) begin
        wait_results_drained(1'b0);
      end
      r = $urandom_range(99);
      if (r < 40) begin
        kind = gkag_pkg::KIND_FORWARD;
      end else if (r < 80) begin
        kind = gkag_pkg::KIND_BACKWARD;
      end else if (r < 90) begin
        kind = KIND_OTHER;
      end else begin
        kind = KIND_UNUSED;
      end
      r = $urandom_range(9);
      if (r < 6) begin
        dt = 16'($urandom);
      end else if (r < 8) begin
        dt = 16'($urandom_range(0, 255));
      end else begin
        // Steps in multiples of 0x1000 can land on segment boundaries and phase zero.
        dt = 16'($urandom_range(0, 15) << 12);
      end
      send_key_event(kind, dt);
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_angles_q.size() == 0) begin
        $display("%0t: result with no pending request, expected none, actual %h",
                 $time, m_axis_tdata);
        err_count++;
      end else begin
        want_angles = expected_angles_q.pop_front();
        for (int j = 0; j < NJ; j++) begin
          if (m_axis_tdata[16*j +: 16] !== want_angles[j]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, joint_names[j],
                     $signed(want_angles[j]), $signed(m_axis_tdata[16*j +: 16]));
            err_count++;
          end
        end
      end
    end
  end

  // Ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    build_ease_weights();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_phase_landmarks();
    test_speed_extremes();
    test_random_events();
    wait_results_drained(1'b1);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/gkag_pkg.sv
src/gkag_ctrl.sv
src/gkag_datapath.sv
src/gait_keyframe_angle_generator_core.sv
src/gkag_checker.sv
dv/tb_gait_keyframe_angle_generator_core.sv
